// ----- sv/bt_tpg_pkg.sv -----
// Shared types and constants for the test payload generator.
package bt_tpg_pkg;

    // Configuration register map (word index = paddr[3:2]).
    localparam int unsigned APB_ADDR_W = 4;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_PACKET_CODE      = 2'd0;
    localparam cfg_index_t REG_REQUESTED_LENGTH = 2'd1;
    localparam cfg_index_t REG_PATTERN_SELECT   = 2'd2;

    // Result field types.
    typedef logic [3:0] pkt_type_t;
    typedef logic [1:0] hdr_kind_t;
    typedef logic [9:0] pay_len_t;
    typedef logic [9:0] byte_idx_t;

    localparam hdr_kind_t HDR_NONE   = 2'd0;
    localparam hdr_kind_t HDR_SINGLE = 2'd1;
    localparam hdr_kind_t HDR_MULTI  = 2'd2;

    // Rate/variant codes held in the high nibble of packet_code.
    localparam logic [3:0] VAR_0 = 4'h0;
    localparam logic [3:0] VAR_1 = 4'h1;
    localparam logic [3:0] VAR_2 = 4'h2;
    localparam logic [3:0] VAR_3 = 4'h3;

    // Packet type codes held in the low nibble of packet_code.
    localparam pkt_type_t TYPE_NULL  = 4'd0;
    localparam pkt_type_t TYPE_POLL  = 4'd1;
    localparam pkt_type_t TYPE_DM1   = 4'd4;
    localparam pkt_type_t TYPE_EV3B  = 4'd6;
    localparam pkt_type_t TYPE_HV3   = 4'd7;
    localparam pkt_type_t TYPE_DH3B  = 4'd8;
    localparam pkt_type_t TYPE_DH1   = 4'd9;
    localparam pkt_type_t TYPE_DH3C  = 4'd10;
    localparam pkt_type_t TYPE_DM3   = 4'd11;
    localparam pkt_type_t TYPE_EV5B  = 4'd12;
    localparam pkt_type_t TYPE_EV5   = 4'd13;
    localparam pkt_type_t TYPE_DH5B  = 4'd14;
    localparam pkt_type_t TYPE_DH5   = 4'd15;

    // Per-type payload limits in bytes.
    localparam pay_len_t LIM_27   = 10'd27;
    localparam pay_len_t LIM_29   = 10'd29;
    localparam pay_len_t LIM_30   = 10'd30;
    localparam pay_len_t LIM_54   = 10'd54;
    localparam pay_len_t LIM_60   = 10'd60;
    localparam pay_len_t LIM_83   = 10'd83;
    localparam pay_len_t LIM_90   = 10'd90;
    localparam pay_len_t LIM_180  = 10'd180;
    localparam pay_len_t LIM_183  = 10'd183;
    localparam pay_len_t LIM_339  = 10'd339;
    localparam pay_len_t LIM_360  = 10'd360;
    localparam pay_len_t LIM_367  = 10'd367;
    localparam pay_len_t LIM_540  = 10'd540;
    localparam pay_len_t LIM_552  = 10'd552;
    localparam pay_len_t LIM_679  = 10'd679;
    localparam pay_len_t LIM_1021 = 10'd1021;

    // Largest length any packet type can resolve to.
    localparam int unsigned MAX_TYPE_LEN = 1021;

    // Pattern select codes.
    localparam logic [7:0] PAT_ZEROS  = 8'd1;
    localparam logic [7:0] PAT_ONES   = 8'd2;
    localparam logic [7:0] PAT_ALT    = 8'd3;
    localparam logic [7:0] PAT_PRBS9  = 8'd4;
    localparam logic [7:0] PAT_NIBBLE = 8'd9;

    localparam logic [7:0] BYTE_ZEROS  = 8'h00;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;
    localparam logic [7:0] BYTE_ALT    = 8'h55;
    localparam logic [7:0] BYTE_NIBBLE = 8'h0F;

    localparam logic [7:0] PRBS_SEED = 8'hFF;

endpackage

// ----- sv/bt_tpg_in_if.sv -----
// Request channel: one transaction asks for the next payload byte.
interface bt_tpg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ----- sv/bt_tpg_out_if.sv -----
// Result channel: one transaction carries one payload byte and its framing.
interface bt_tpg_out_if;
    logic                  valid;
    logic                  ready;
    bt_tpg_pkg::pkt_type_t resolved_type;
    bt_tpg_pkg::hdr_kind_t header_kind;
    bt_tpg_pkg::pay_len_t  payload_length;
    bt_tpg_pkg::byte_idx_t byte_index;
    logic [7:0]            payload_byte;
    logic                  byte_valid;
    logic                  last_byte;

    modport source (output valid, output resolved_type, output header_kind,
                    output payload_length, output byte_index, output payload_byte,
                    output byte_valid, output last_byte, input ready);
    modport sink   (input valid, input resolved_type, input header_kind,
                    input payload_length, input byte_index, input payload_byte,
                    input byte_valid, input last_byte, output ready);
endinterface

// ----- sv/bt_test_payload_generator.sv -----
// Top level of the transmitter test payload generator.
//
// Usage: program packet_code, requested_length and pattern_select over the
// APB port (byte addresses 0, 4 and 8) while the block is idle. Each
// transaction on in_ch requests the next payload byte; restart = 1 reloads
// the PRBS9 sequence and the byte index before that byte is produced. Each
// request yields exactly one transaction on out_ch carrying the resolved
// packet type, header kind, clamped length, the byte index and the byte.
// Requests past the end of the payload report byte_valid = 0 and do not
// advance the index.
//
// A request passes through the request register and then the result
// register before its result appears on out_ch. While out_ch does not
// stall, the throughput is one transaction per cycle; the eight-step
// PRBS9 update is unrolled between the registers, so a byte is produced
// every cycle. When out_ch stalls, the result register holds and the
// request register still absorbs one more request before in_ch.ready drops.
//
// Reset clears the configuration registers to zero, seeds the PRBS register
// with all ones and its output bit with one, sets the index to zero and
// empties both pipeline registers.
module bt_test_payload_generator #(
    parameter int unsigned PAYLOAD_BUFFER_BYTES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bt_tpg_in_if.sink                         in_ch,
    bt_tpg_out_if.source                      out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bt_tpg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned LEN_MAX = (PAYLOAD_BUFFER_BYTES > bt_tpg_pkg::MAX_TYPE_LEN) ?
                                      PAYLOAD_BUFFER_BYTES : bt_tpg_pkg::MAX_TYPE_LEN;
    localparam int unsigned LEN_W   = $clog2(LEN_MAX + 1);
    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(PAYLOAD_BUFFER_BYTES);

    // Configuration registers.
    logic [7:0]  packet_code_reg;
    logic [15:0] requested_length_reg;
    logic [7:0]  pattern_select_reg;

    bt_tpg_pkg::cfg_index_t cfg_idx;
    logic                   cfg_write;

    // Generator state.
    logic [7:0]            prbs_reg,     prbs_next;
    logic                  prbs_bit_reg, prbs_bit_next;
    bt_tpg_pkg::byte_idx_t idx_reg,      idx_next;

    // Pipeline.
    logic s1_valid_reg;
    logic s1_restart_reg;
    logic s1_fire;
    logic out_valid_reg;

    // Resolution results.
    bt_tpg_pkg::pkt_type_t res_type;
    bt_tpg_pkg::hdr_kind_t res_hdr;
    bt_tpg_pkg::pay_len_t  res_len;

    // Per-byte results.
    bt_tpg_pkg::byte_idx_t cur_idx;
    logic [7:0]            cur_byte;
    logic                  cur_valid;
    logic                  cur_last;

    //------------------------------------------------------------------
    // APB configuration port.
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_code_reg      <= '0;
            requested_length_reg <= '0;
            pattern_select_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                bt_tpg_pkg::REG_PACKET_CODE:      packet_code_reg      <= pwdata[7:0];
                bt_tpg_pkg::REG_REQUESTED_LENGTH: requested_length_reg <= pwdata[15:0];
                bt_tpg_pkg::REG_PATTERN_SELECT:   pattern_select_reg   <= pwdata[7:0];
                default:                          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bt_tpg_pkg::REG_PACKET_CODE:      prdata = {24'd0, packet_code_reg};
            bt_tpg_pkg::REG_REQUESTED_LENGTH: prdata = {16'd0, requested_length_reg};
            bt_tpg_pkg::REG_PATTERN_SELECT:   prdata = {24'd0, pattern_select_reg};
            default:                          prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Packet type, header kind and length resolution.
    //------------------------------------------------------------------
    always_comb
    begin
        logic [3:0]       type_code;
        logic [3:0]       var_code;
        logic [LEN_W-1:0] req_len;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] lim_ext;
        bt_tpg_pkg::pay_len_t  lim;
        bt_tpg_pkg::hdr_kind_t hdr;
        logic ok;
        logic esco;
        logic zero_len;
        logic fixed_len;
        logic pat_ok;

        type_code = packet_code_reg[3:0];
        var_code  = packet_code_reg[7:4];
        ok        = 1'b1;
        esco      = 1'b0;
        zero_len  = 1'b0;
        fixed_len = 1'b0;
        hdr       = bt_tpg_pkg::HDR_NONE;
        lim       = '0;

        // Requests beyond the buffer are trimmed first.
        if (requested_length_reg > 16'(BUF_LEN))
            req_len = BUF_LEN;
        else
            req_len = LEN_W'(requested_length_reg);

        case (type_code)
            bt_tpg_pkg::TYPE_NULL, bt_tpg_pkg::TYPE_POLL:
                zero_len = 1'b1;
            bt_tpg_pkg::TYPE_DM1:
                if (var_code == bt_tpg_pkg::VAR_0)
                begin
                    hdr = bt_tpg_pkg::HDR_SINGLE;
                    lim = bt_tpg_pkg::LIM_27;
                end
                else if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_54;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_EV3B:
                if (var_code == bt_tpg_pkg::VAR_3)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_60;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_HV3:
                if (var_code == bt_tpg_pkg::VAR_0)
                    fixed_len = 1'b1;
                else if (var_code == bt_tpg_pkg::VAR_1)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_30;
                end
                else if (var_code == bt_tpg_pkg::VAR_3)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_90;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DH3B:
                if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_83;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DH1:
                if (var_code == bt_tpg_pkg::VAR_0 || var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_SINGLE;
                    lim = bt_tpg_pkg::LIM_29;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DH3C:
                if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_367;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DM3:
                if (var_code == bt_tpg_pkg::VAR_0)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_183;
                end
                else if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_552;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_EV5B:
                if (var_code == bt_tpg_pkg::VAR_3)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_360;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_EV5:
                if (var_code == bt_tpg_pkg::VAR_1)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_180;
                end
                else if (var_code == bt_tpg_pkg::VAR_3)
                begin
                    esco = 1'b1;
                    lim  = bt_tpg_pkg::LIM_540;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DH5B:
                if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_679;
                end
                else
                    ok = 1'b0;
            bt_tpg_pkg::TYPE_DH5:
                if (var_code == bt_tpg_pkg::VAR_0)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_339;
                end
                else if (var_code == bt_tpg_pkg::VAR_2)
                begin
                    hdr = bt_tpg_pkg::HDR_MULTI;
                    lim = bt_tpg_pkg::LIM_1021;
                end
                else
                    ok = 1'b0;
            default:
                ok = 1'b0;
        endcase

        lim_ext = LEN_W'(lim);
        len     = req_len;
        if (zero_len)
            len = '0;
        if (fixed_len)
            len = LEN_W'(bt_tpg_pkg::LIM_30);

        // eSCO types fill an empty or oversized request with the full size.
        if (ok && lim != '0)
        begin
            if (esco)
            begin
                if (len > lim_ext || len == '0)
                    len = lim_ext;
            end
            else if (len > lim_ext)
                len = lim_ext;
        end

        if (!ok)
        begin
            type_code = '0;
            hdr       = bt_tpg_pkg::HDR_NONE;
            len       = '0;
        end

        if (len > BUF_LEN)
            len = BUF_LEN;

        pat_ok = pattern_select_reg inside {bt_tpg_pkg::PAT_ZEROS, bt_tpg_pkg::PAT_ONES,
                                            bt_tpg_pkg::PAT_ALT, bt_tpg_pkg::PAT_PRBS9,
                                            bt_tpg_pkg::PAT_NIBBLE};
        if (len != '0 && !pat_ok)
        begin
            type_code = '0;
            hdr       = bt_tpg_pkg::HDR_NONE;
            len       = '0;
        end

        res_type = type_code;
        res_hdr  = hdr;
        res_len  = bt_tpg_pkg::pay_len_t'(len);
    end

    //------------------------------------------------------------------
    // Byte generation and state update for the request in stage 1.
    //------------------------------------------------------------------
    always_comb
    begin
        logic [7:0] lfsr;
        logic       obit;
        logic       fb;
        logic [7:0] prbs_byte;

        cur_idx = s1_restart_reg ? '0 : idx_reg;
        lfsr    = s1_restart_reg ? bt_tpg_pkg::PRBS_SEED : prbs_reg;
        obit    = s1_restart_reg ? 1'b1 : prbs_bit_reg;

        prbs_next     = lfsr;
        prbs_bit_next = obit;

        // Eight PRBS9 steps; the output bit acts as the ninth register stage.
        prbs_byte = '0;
        for (int i = 0; i < 8; i++)
        begin
            prbs_byte[i] = obit;
            fb           = lfsr[4] ^ obit;
            obit         = lfsr[7];
            lfsr         = {lfsr[6:0], fb};
        end

        cur_valid = cur_idx < res_len;
        cur_last  = cur_valid && ({1'b0, cur_idx} + 11'd1 == {1'b0, res_len});

        case (pattern_select_reg)
            bt_tpg_pkg::PAT_ZEROS:  cur_byte = bt_tpg_pkg::BYTE_ZEROS;
            bt_tpg_pkg::PAT_ONES:   cur_byte = bt_tpg_pkg::BYTE_ONES;
            bt_tpg_pkg::PAT_ALT:    cur_byte = bt_tpg_pkg::BYTE_ALT;
            bt_tpg_pkg::PAT_NIBBLE: cur_byte = bt_tpg_pkg::BYTE_NIBBLE;
            bt_tpg_pkg::PAT_PRBS9:  cur_byte = prbs_byte;
            default:                cur_byte = bt_tpg_pkg::BYTE_ZEROS;
        endcase
        if (!cur_valid)
            cur_byte = bt_tpg_pkg::BYTE_ZEROS;

        if (cur_valid && pattern_select_reg == bt_tpg_pkg::PAT_PRBS9)
        begin
            prbs_next     = lfsr;
            prbs_bit_next = obit;
        end

        // The index stays below the length, so it cannot wrap here.
        idx_next = cur_valid ? cur_idx + 10'd1 : cur_idx;
    end

    //------------------------------------------------------------------
    // Pipeline control.
    //------------------------------------------------------------------
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_fire;
    assign out_ch.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prbs_reg      <= bt_tpg_pkg::PRBS_SEED;
            prbs_bit_reg  <= 1'b1;
            idx_reg       <= '0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                prbs_reg      <= prbs_next;
                prbs_bit_reg  <= prbs_bit_next;
                idx_reg       <= idx_next;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            s1_restart_reg <= in_ch.restart;
        if (s1_fire)
        begin
            out_ch.resolved_type  <= res_type;
            out_ch.header_kind    <= res_hdr;
            out_ch.payload_length <= res_len;
            out_ch.byte_index     <= cur_idx;
            out_ch.payload_byte   <= cur_byte;
            out_ch.byte_valid     <= cur_valid;
            out_ch.last_byte      <= cur_last;
        end
    end

`ifndef SYNTHESIS
    // A valid byte always lies inside the resolved payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ch.byte_valid |-> out_ch.byte_index < out_ch.payload_length)
        else $error("valid byte outside payload length");

    // The final byte flag only appears on a valid byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ch.last_byte |-> out_ch.byte_valid)
        else $error("last_byte set on an invalid byte");

    // Bytes past the end are reported as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.byte_valid |-> out_ch.payload_byte == 8'h00)
        else $error("invalid byte is not zero");

    // The index never runs beyond the largest possible payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 10'(bt_tpg_pkg::MAX_TYPE_LEN))
        else $error("byte index ran past the longest payload");

    // Generator state only moves when a request moves into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(idx_reg) && $stable(prbs_reg))
        else $error("generator state changed without a transaction");
`endif

endmodule
